>>> src/polar_gaussian_sample_clamped_assert.svh
// Assertion macros for the checker file.
`ifndef POLAR_GAUSSIAN_SAMPLE_CLAMPED_ASSERT_SVH
`define POLAR_GAUSSIAN_SAMPLE_CLAMPED_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PGS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pgs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define PGS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pgs assertion failed");

`endif

>>> src/pgs_pkg.sv
`timescale 1ns / 1ps
package pgs_pkg;

  localparam int FRAC_BITS = 16;

  // Stream payload widths
  localparam int IN_DATA_W = 168;
  localparam int OUT_DATA_W = 32;

  // Datapath widths
  localparam int R_W       = 36;  // x^2 + y^2
  localparam int LG_STEPS  = 24;  // fraction bits of log2
  localparam int MUL_W     = 32;
  localparam int MUL_DIGIT = 8;
  localparam int DIV_W     = 32;
  localparam int ROOT_W    = 20;
  localparam int RAD_W     = 2 * ROOT_W;
  localparam int SPARE_W   = 24;

  // ln(2) in Q2.30
  localparam logic [31:0] LN2_Q30 = 32'd744261118;

  typedef enum logic [1:0] {
    STAT_FRESH  = 2'd0,
    STAT_SPARE  = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

endpackage

>>> src/pgs_mul.sv
`timescale 1ns / 1ps
// Digit-serial multiplier: one MUL_DIGIT slice of b per cycle, MSB first.
module pgs_mul (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pgs_pkg::MUL_W-1:0]      a_i,
  input  logic [pgs_pkg::MUL_W-1:0]      b_i,
  output logic                           done_o,
  output logic [2*pgs_pkg::MUL_W-1:0]    prod_o
);
  localparam int W     = pgs_pkg::MUL_W;
  localparam int D     = pgs_pkg::MUL_DIGIT;
  localparam int Steps = W / D;
  localparam int CntW  = (Steps > 1) ? $clog2(Steps) : 1;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    a_q, b_q;
  logic [2*W-1:0]  acc_q;
  logic [W+D-1:0]  part;

  assign part = (W+D)'(a_q) * (W+D)'(b_q[W-1 -: D]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(Steps - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= (acc_q << D) + (2*W)'(part);
      b_q   <= b_q << D;
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

>>> src/pgs_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle: quot = (num * 2^DIV_W) / den.
// num must be below den.
module pgs_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [pgs_pkg::DIV_W-1:0] num_i,
  input  logic [pgs_pkg::DIV_W-1:0] den_i,
  output logic                      done_o,
  output logic [pgs_pkg::DIV_W-1:0] quot_o
);
  localparam int W    = pgs_pkg::DIV_W;
  localparam int CntW = $clog2(W);

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [W-1:0]    rem_q, den_q, quot_q;
  logic [W:0]      rem_sh;
  logic            ge;

  assign rem_sh = {rem_q, 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      den_q  <= den_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? W'(rem_sh - {1'b0, den_q}) : rem_sh[W-1:0];
      quot_q <= {quot_q[W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

>>> src/pgs_sqrt.sv
`timescale 1ns / 1ps
// Digit-by-digit integer square root, two radicand bits and one root bit per cycle.
module pgs_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [pgs_pkg::RAD_W-1:0]  rad_i,
  output logic                       done_o,
  output logic [pgs_pkg::ROOT_W-1:0] root_o
);
  localparam int RW   = pgs_pkg::ROOT_W;
  localparam int AW   = pgs_pkg::RAD_W;
  localparam int CntW = $clog2(RW);
  localparam int RemW = RW + 4;

  logic            busy_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [AW-1:0]   rad_q;
  logic [RW-1:0]   root_q;
  logic [RemW-1:0] rem_q, rem_sh, trial;
  logic            ge;

  assign rem_sh = {rem_q[RemW-3:0], rad_q[AW-1 -: 2]};
  assign trial  = RemW'({root_q, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(RW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= ge ? rem_sh - trial : rem_sh;
      root_q <= {root_q[RW-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

>>> src/polar_gaussian_sample_clamped.sv
`timescale 1ns / 1ps
// Clamped Gaussian sampler, polar method, Q16.16 by default.
// Input channel s_axis_*: one transaction per request carrying mean, deviation,
// clamp bounds and two uniform draws in [-1,1]. Output channel m_axis_*: one
// transaction per request, sample in tdata and status in tuser (fresh, spare
// used, or draws rejected; a rejected request returns sample zero and should
// be retried with new draws).
// One request is in work at a time. A request served from the held spare
// skips the draws and goes straight to scaling, and a rejected one ends after
// the range check. A fresh pair walks the leading one of r to bit 31 in the
// normalizer, runs the 24 squarings of the base-2 logarithm on the shared
// 8-bit-digit multiplier, then the divider and the root, before scaling.
// The result sits in an output register, so s_axis_tready rises again as soon
// as the result is stored even while the receiver stalls; a second result
// waits inside until the register is taken.
// Reset clears the spare, the sequencer and the output valid.
module polar_gaussian_sample_clamped #(
  parameter int FRAC_BITS = pgs_pkg::FRAC_BITS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] mean_value, [63:32] deviation, [95:64] lower_bound,
  // [127:96] upper_bound, [145:128] uniform_x, [163:146] uniform_y, [167:164] zero
  input  logic [pgs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [pgs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,  // [31:0] sample
  output logic [1:0]                      m_axis_tuser   // [1:0] status
);
  localparam int EW = $clog2(2 * FRAC_BITS + 1);
  localparam int RW = pgs_pkg::R_W;
  localparam int CW = (2 * FRAC_BITS + 1 > RW) ? 2 * FRAC_BITS + 2 : RW + 1;
  localparam logic [CW-1:0] R_ONE  = {{(CW-1){1'b0}}, 1'b1} << (2 * FRAC_BITS);
  localparam logic [63:0]   HALF_F = 64'd1 << (FRAC_BITS - 1);
  localparam int SW = pgs_pkg::SPARE_W;
  localparam logic signed [SW-1:0] SPARE_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SPARE_MIN = {1'b1, {(SW-1){1'b0}}};

  typedef enum logic [14:0] {
    ST_IDLE  = 15'h0001,
    ST_SQX   = 15'h0002,
    ST_SQY   = 15'h0004,
    ST_CHECK = 15'h0008,
    ST_NORM  = 15'h0010,
    ST_LOG   = 15'h0020,
    ST_LN2   = 15'h0040,
    ST_DIV   = 15'h0080,
    ST_ROOT  = 15'h0100,
    ST_NX    = 15'h0200,
    ST_NY    = 15'h0400,
    ST_SCALE = 15'h0800,
    ST_SUM   = 15'h1000,
    ST_CLAMP = 15'h2000,
    ST_OUT   = 15'h4000
  } state_e;

  // Control state
  state_e state_q, state_d;
  logic   issued_q, issued_d;
  logic   spare_vld_q, spare_vld_d;
  logic   mval_q, mval_d;

  // Request and datapath registers
  logic signed [31:0]    mean_q, mean_d, dev_q, dev_d, lo_q, lo_d, hi_q, hi_d;
  logic signed [17:0]    x_q, x_d, y_q, y_d;
  logic signed [SW-1:0]  spare_q, spare_d;
  pgs_pkg::status_e      status_q, status_d;
  logic [RW-1:0]         r_q, r_d;
  logic [5:0]            p_q, p_d;
  logic [EW-1:0]         e_q, e_d;
  logic [31:0]           m_q, m_d, z_q, z_d, t_q, t_d;
  logic [pgs_pkg::LG_STEPS-1:0] lg_q, lg_d;
  logic [4:0]            cnt_q, cnt_d;
  logic [32:0]           a_q, a_d;
  logic [pgs_pkg::ROOT_W-1:0] d_q, d_d;
  logic [31:0]           nmag_q, nmag_d;
  logic                  nneg_q, nneg_d;
  logic [63:0]           sc_q, sc_d;
  logic signed [65:0]    sum_q, sum_d;
  logic signed [31:0]    res_q, res_d;
  logic [31:0]           mdata_q;
  pgs_pkg::status_e      muser_q;

  // Unit handshakes
  logic        mul_start, mul_done, div_start, div_done, root_start, root_done;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_prod;
  logic [31:0] div_quot;
  logic [pgs_pkg::ROOT_W-1:0] root_val;

  // Helpers
  logic [17:0]        xmag, ymag;
  logic [31:0]        devmag;
  logic [SW-1:0]      spare_mag;
  logic [32:0]        zz;
  logic [EW-2:0]      half_e;
  logic [63:0]        shifted, rnd_full;
  logic [47:0]        rnd;
  logic signed [65:0] sc_s;
  logic signed [31:0] sat;
  logic               accept, load_out;

  assign xmag      = x_q[17] ? 18'(-x_q) : 18'(x_q);
  assign ymag      = y_q[17] ? 18'(-y_q) : 18'(y_q);
  assign devmag    = dev_q[31] ? 32'(-dev_q) : 32'(dev_q);
  assign spare_mag = spare_q[SW-1] ? SW'(-spare_q) : SW'(spare_q);
  assign zz        = mul_prod[63:31];
  assign half_e    = e_q[EW-1:1];
  assign shifted   = mul_prod << half_e;
  assign rnd_full  = (shifted + 64'd32768) >> 16;
  assign rnd       = rnd_full[47:0];
  assign sc_s      = $signed({2'b00, sc_q});

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign load_out      = (state_q == ST_OUT) && (!mval_q || m_axis_tready);

  // Operand select for the shared multiplier
  always_comb begin
    case (state_q)
      ST_SQX:   begin mul_a = 32'(xmag);  mul_b = 32'(xmag); end
      ST_SQY:   begin mul_a = 32'(ymag);  mul_b = 32'(ymag); end
      ST_LOG:   begin mul_a = z_q;        mul_b = z_q; end
      ST_LN2:   begin
        mul_a = (32'(e_q) << 24) - 32'(lg_q);
        mul_b = pgs_pkg::LN2_Q30;
      end
      ST_NX:    begin mul_a = 32'(xmag);  mul_b = 32'(d_q); end
      ST_NY:    begin mul_a = 32'(ymag);  mul_b = 32'(d_q); end
      ST_SCALE: begin mul_a = nmag_q;     mul_b = devmag; end
      default:  begin mul_a = '0;         mul_b = '0; end
    endcase
  end

  assign mul_start  = !issued_q && (state_q inside {ST_SQX, ST_SQY, ST_LOG, ST_LN2,
                                                    ST_NX, ST_NY, ST_SCALE});
  assign div_start  = !issued_q && (state_q == ST_DIV);
  assign root_start = !issued_q && (state_q == ST_ROOT);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    spare_vld_d = spare_vld_q;
    mean_d = mean_q; dev_d = dev_q; lo_d = lo_q; hi_d = hi_q;
    x_d = x_q; y_d = y_q;
    spare_d  = spare_q;
    status_d = status_q;
    r_d = r_q; p_d = p_q; e_d = e_q; m_d = m_q; z_d = z_q; t_d = t_q;
    lg_d = lg_q; cnt_d = cnt_q; a_d = a_q; d_d = d_q;
    nmag_d = nmag_q; nneg_d = nneg_q;
    sc_d = sc_q; sum_d = sum_q; res_d = res_q;
    sat = '0;

    if (mul_start || div_start || root_start) begin
      issued_d = 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mean_d = s_axis_tdata[31:0];
          dev_d  = s_axis_tdata[63:32];
          lo_d   = s_axis_tdata[95:64];
          hi_d   = s_axis_tdata[127:96];
          x_d    = s_axis_tdata[145:128];
          y_d    = s_axis_tdata[163:146];
          if (spare_vld_q) begin
            // Serve from the held spare, no draws needed
            nmag_d      = 32'(spare_mag);
            nneg_d      = spare_q[SW-1];
            spare_vld_d = 1'b0;
            status_d    = pgs_pkg::STAT_SPARE;
            state_d     = ST_SCALE;
          end else begin
            status_d = pgs_pkg::STAT_FRESH;
            state_d  = ST_SQX;
          end
        end
      end
      ST_SQX: begin
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          r_d      = RW'(mul_prod);
          state_d  = ST_SQY;
        end
      end
      ST_SQY: begin
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          r_d      = r_q + RW'(mul_prod);
          state_d  = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (r_q == '0 || CW'(r_q) > R_ONE) begin
          status_d = pgs_pkg::STAT_REJECT;
          res_d    = '0;
          state_d  = ST_OUT;
        end else begin
          p_d     = 6'd31;
          state_d = ST_NORM;
        end
      end
      ST_NORM: begin
        // Walk the leading one to bit 31, tracking its original position
        if (r_q[RW-1:32] != '0) begin
          r_d = r_q >> 1;
          p_d = p_q + 1'b1;
        end else if (!r_q[31]) begin
          r_d = r_q << 1;
          p_d = p_q - 1'b1;
        end else begin
          m_d     = r_q[31:0];
          z_d     = r_q[31:0];
          e_d     = EW'(2 * FRAC_BITS) - EW'(p_q);
          lg_d    = '0;
          cnt_d   = 5'(pgs_pkg::LG_STEPS - 1);
          state_d = ST_LOG;
        end
      end
      ST_LOG: begin
        // One log2 fraction bit per squaring
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          if (zz[32]) begin
            z_d        = zz[32:1];
            lg_d[cnt_q] = 1'b1;
          end else begin
            z_d = zz[31:0];
          end
          if (cnt_q == '0) begin
            state_d = ST_LN2;
          end else begin
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      ST_LN2: begin
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          t_d      = mul_prod[60:29];
          state_d  = ST_DIV;
        end
      end
      ST_DIV: begin
        if (issued_q && div_done) begin
          issued_d = 1'b0;
          if (e_q[0]) begin
            a_d = {div_quot, 1'b0};
            e_d = e_q - 1'b1;
          end else begin
            a_d = {1'b0, div_quot};
          end
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (issued_q && root_done) begin
          issued_d = 1'b0;
          d_d      = root_val;
          state_d  = ST_NX;
        end
      end
      ST_NX: begin
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          nmag_d   = rnd[31:0];
          nneg_d   = x_q[17];
          state_d  = ST_NY;
        end
      end
      ST_NY: begin
        // Keep y*d as the spare, saturated to its storage width
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          if (y_q[17]) begin
            spare_d = (rnd > 48'(1 << (SW - 1))) ? SPARE_MIN : -$signed(SW'(rnd));
          end else begin
            spare_d = (rnd > 48'(SPARE_MAX)) ? SPARE_MAX : $signed(SW'(rnd));
          end
          spare_vld_d = 1'b1;
          state_d     = ST_SCALE;
        end
      end
      ST_SCALE: begin
        if (issued_q && mul_done) begin
          issued_d = 1'b0;
          sc_d     = (mul_prod + HALF_F) >> FRAC_BITS;
          state_d  = ST_SUM;
        end
      end
      ST_SUM: begin
        sum_d   = ((nneg_q ^ dev_q[31]) ? -sc_s : sc_s) + 66'(mean_q);
        state_d = ST_CLAMP;
      end
      ST_CLAMP: begin
        if (sum_q > 66'sd2147483647) begin
          sat = 32'sh7fffffff;
        end else if (sum_q < -66'sd2147483648) begin
          sat = 32'sh80000000;
        end else begin
          sat = sum_q[31:0];
        end
        // Ceiling first, then floor
        if (sat > hi_q) begin
          res_d = hi_q;
        end else if (sat < lo_q) begin
          res_d = lo_q;
        end else begin
          res_d = sat;
        end
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    mval_d = mval_q;
    if (m_axis_tready) begin
      mval_d = 1'b0;
    end
    if (load_out) begin
      mval_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      spare_vld_q <= 1'b0;
      spare_q     <= '0;
      mval_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      spare_vld_q <= spare_vld_d;
      spare_q     <= spare_d;
      mval_q      <= mval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mean_q <= mean_d; dev_q <= dev_d; lo_q <= lo_d; hi_q <= hi_d;
    x_q <= x_d; y_q <= y_d;
    status_q <= status_d;
    r_q <= r_d; p_q <= p_d; e_q <= e_d; m_q <= m_d; z_q <= z_d; t_q <= t_d;
    lg_q <= lg_d; cnt_q <= cnt_d; a_q <= a_d; d_q <= d_d;
    nmag_q <= nmag_d; nneg_q <= nneg_d;
    sc_q <= sc_d; sum_q <= sum_d; res_q <= res_d;
    if (load_out) begin
      mdata_q <= res_q;
      muser_q <= status_q;
    end
  end

  pgs_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  pgs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q),
    .den_i   (m_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  pgs_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   ({a_q, 7'b0}),
    .done_o  (root_done),
    .root_o  (root_val)
  );

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = mdata_q;
  assign m_axis_tuser  = muser_q;

endmodule

>>> src/pgs_checker.sv
`timescale 1ns / 1ps
`include "polar_gaussian_sample_clamped_assert.svh"
module pgs_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [pgs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [1:0]                     m_axis_tuser
);
  logic out_acc, last_fresh_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_fresh_q <= 1'b0;
    end else if (out_acc) begin
      last_fresh_q <= (m_axis_tuser == pgs_pkg::STAT_FRESH);
    end
  end

  `PGS_ASSERT_NOW(a_reject_zero, m_axis_tvalid && m_axis_tuser == pgs_pkg::STAT_REJECT,
                  m_axis_tdata == '0)
  `PGS_ASSERT_NOW(a_spare_after_fresh, out_acc && last_fresh_q,
                  m_axis_tuser == pgs_pkg::STAT_SPARE)
  `PGS_ASSERT_NOW(a_no_spare_unheld, out_acc && !last_fresh_q,
                  m_axis_tuser != pgs_pkg::STAT_SPARE)
  `PGS_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `PGS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind polar_gaussian_sample_clamped pgs_checker u_pgs_checker (.*);
